[design/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion lbl failed");
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("assertion lbl failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

[design/rayobb_pkg.sv]
`default_nettype none
package rayobb_pkg;

    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int LEN_W     = 31;
    localparam int P_W       = 33;
    localparam int E_W       = 51;
    localparam int F_W       = 50;
    localparam int N_W       = 52;
    localparam int DIV_BITS  = 32;
    localparam int DIV_LAT   = DIV_BITS + 1;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_XY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z_EA = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_BC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_A_XY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_AZ_BX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_B_YZ   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_C_XY   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_C_Z    = 3'd7;

    localparam logic signed [31:0] T_LOW  = 32'sh8000_0000;
    localparam logic signed [31:0] T_HIGH = 32'sh7fff_ffff;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic [LEN_W-1:0]   segment_length;
        logic               func;
    } in_t;

    typedef struct packed {
        logic             hit;
        logic [LEN_W-1:0] distance;
    } out_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [P_W-1:0] x;
        logic signed [P_W-1:0] y;
        logic signed [P_W-1:0] z;
    } pvec_t;

endpackage
`default_nettype wire

[design/rayobb_dot.sv]
`default_nettype none
// axis dot products against offset and direction, two register stages
module rayobb_dot (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire rayobb_pkg::vec_t                axis,
    input  wire rayobb_pkg::pvec_t               p,
    input  wire rayobb_pkg::vec_t                dir,
    output logic signed [rayobb_pkg::E_W-1:0]    e,
    output logic signed [rayobb_pkg::F_W-1:0]    f
);
    localparam int PP_W = 32 + rayobb_pkg::P_W;
    localparam int PD_W = 64;

    logic signed [PP_W-1:0] pp_reg [3];
    logic signed [PD_W-1:0] pd_reg [3];
    logic signed [rayobb_pkg::E_W-1:0] e_reg;
    logic signed [rayobb_pkg::F_W-1:0] f_reg;
    logic signed [rayobb_pkg::E_W-1:0] e_next;
    logic signed [rayobb_pkg::F_W-1:0] f_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg[0] <= PP_W'(axis.x) * PP_W'(p.x);
            pp_reg[1] <= PP_W'(axis.y) * PP_W'(p.y);
            pp_reg[2] <= PP_W'(axis.z) * PP_W'(p.z);
            pd_reg[0] <= PD_W'(axis.x) * PD_W'(dir.x);
            pd_reg[1] <= PD_W'(axis.y) * PD_W'(dir.y);
            pd_reg[2] <= PD_W'(axis.z) * PD_W'(dir.z);
        end
    end

    // floor shift by 16 is the arithmetic part-select of each product
    always_comb
    begin
        e_next = '0;
        f_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            e_next = e_next + {{2{pp_reg[i][PP_W-1]}}, pp_reg[i][PP_W-1:16]};
            f_next = f_next + {{2{pd_reg[i][PD_W-1]}}, pd_reg[i][PD_W-1:16]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg <= e_next;
            f_reg <= f_next;
        end
    end

    assign e = e_reg;
    assign f = f_reg;
endmodule
`default_nettype wire

[design/rayobb_div.sv]
`default_nettype none
// saturating q16.16 quotient, one quotient bit per stage
module rayobb_div (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [rayobb_pkg::N_W-1:0]   num,
    input  wire logic signed [rayobb_pkg::F_W-1:0]   den,
    output logic signed [31:0]                       t
);
    localparam int NB    = rayobb_pkg::DIV_BITS;
    localparam int NW    = rayobb_pkg::N_W;
    localparam int DW    = rayobb_pkg::F_W;
    localparam int REM_W = NW + 16;
    localparam int CMP_W = DW + NB;
    localparam int OVF_W = DW + 16;

    logic [REM_W-1:0] rem_reg [NB+1];
    logic [DW-1:0]    d_reg   [NB+1];
    logic [NB-1:0]    q_reg   [NB+1];
    logic             ovf_reg [NB+1];
    logic             neg_reg [NB+1];

    logic [NW-1:0] nmag;
    logic [DW-1:0] dmag;
    logic          ovf0;

    always_comb
    begin
        nmag = num[NW-1] ? NW'(-num) : NW'(num);
        dmag = den[DW-1] ? DW'(-den) : DW'(den);
        // integer part of 0x8000 or more saturates
        ovf0 = OVF_W'(nmag) >= {dmag, 15'd0, 1'b0} >> 1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {nmag, 16'd0};
            d_reg[0]   <= dmag;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf0;
            neg_reg[0] <= num[NW-1] != den[DW-1];
        end
    end

    for (genvar k = 1; k <= NB; k++)
    begin : g_stage
        localparam int SH = NB - k;
        logic [CMP_W-1:0] dsh;
        logic             take;

        assign dsh  = CMP_W'(d_reg[k-1]) << SH;
        assign take = CMP_W'(rem_reg[k-1]) >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? REM_W'(CMP_W'(rem_reg[k-1]) - dsh) : rem_reg[k-1];
                d_reg[k]   <= d_reg[k-1];
                q_reg[k]   <= q_reg[k-1] | (NB'(take) << SH);
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    always_comb
    begin
        if (neg_reg[NB])
            t = ovf_reg[NB] ? rayobb_pkg::T_LOW : -signed'(q_reg[NB]);
        else
            t = ovf_reg[NB] ? rayobb_pkg::T_HIGH : signed'(q_reg[NB]);
    end
endmodule
`default_nettype wire

[design/ray_obb_slab_intersect_unit.sv]
`default_nettype none
`include "assert_macros.svh"
// Ray / segment against one oriented box, three-slab test in Q16.16. One word
// is taken every cycle while in_stall is low and passes through five stages
// for input capture, origin offset, two dot-product stages and slab
// numerators, 33 stages of the six pipelined dividers (one quotient bit per
// stage), then three stages for slab ordering, interval merge and the final
// mode select. A skid register catches a result that meets out_stall; the
// pipeline and input hold while it is full. The user is to write box
// registers through cfg_we / cfg_index / cfg_data while idle (not enforced).
module ray_obb_slab_intersect_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire rayobb_pkg::in_t                      in_data,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output rayobb_pkg::out_t                          out_data,
    input  wire logic                                 cfg_we,
    input  wire logic [rayobb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rayobb_pkg::CFG_W-1:0]         cfg_data
);
    localparam int NSTG = 5 + rayobb_pkg::DIV_LAT + 3;
    localparam int LAST = NSTG - 1;
    localparam int LW   = rayobb_pkg::LEN_W;

    typedef struct packed {
        logic [LW-1:0] len;
        logic          func;
        logic [2:0]    par;
        logic [2:0]    pok;
    } side_t;

    logic [rayobb_pkg::CFG_W-1:0] cfg_reg [rayobb_pkg::NUM_REGS];
    logic [NSTG-1:0]              vld_reg;
    logic                         en;
    logic                         skid_full_reg;
    rayobb_pkg::out_t             skid_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rayobb_pkg::NUM_REGS; i++)
                cfg_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    logic signed [31:0] cen_x, cen_y, cen_z;
    logic signed [31:0] ext [3];
    rayobb_pkg::vec_t   axis [3];

    always_comb
    begin
        cen_x     = cfg_reg[rayobb_pkg::REG_CENTER_XY][31:0];
        cen_y     = cfg_reg[rayobb_pkg::REG_CENTER_XY][63:32];
        cen_z     = cfg_reg[rayobb_pkg::REG_CENTER_Z_EA][31:0];
        ext[0]    = cfg_reg[rayobb_pkg::REG_CENTER_Z_EA][63:32];
        ext[1]    = cfg_reg[rayobb_pkg::REG_EXTENT_BC][31:0];
        ext[2]    = cfg_reg[rayobb_pkg::REG_EXTENT_BC][63:32];
        axis[0].x = cfg_reg[rayobb_pkg::REG_AXIS_A_XY][31:0];
        axis[0].y = cfg_reg[rayobb_pkg::REG_AXIS_A_XY][63:32];
        axis[0].z = cfg_reg[rayobb_pkg::REG_AXIS_AZ_BX][31:0];
        axis[1].x = cfg_reg[rayobb_pkg::REG_AXIS_AZ_BX][63:32];
        axis[1].y = cfg_reg[rayobb_pkg::REG_AXIS_B_YZ][31:0];
        axis[1].z = cfg_reg[rayobb_pkg::REG_AXIS_B_YZ][63:32];
        axis[2].x = cfg_reg[rayobb_pkg::REG_AXIS_C_XY][31:0];
        axis[2].y = cfg_reg[rayobb_pkg::REG_AXIS_C_XY][63:32];
        axis[2].z = cfg_reg[rayobb_pkg::REG_AXIS_C_Z][31:0];
    end

    // whole pipeline advances unless the skid register is occupied
    assign en       = !skid_full_reg;
    assign in_stall = skid_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
    end

    // stage a: capture
    rayobb_pkg::in_t a_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            a_reg <= in_data;
    end

    // stage b: offset from origin to center
    rayobb_pkg::pvec_t b_p_reg;
    rayobb_pkg::vec_t  b_dir_reg;
    logic [LW-1:0]     b_len_reg;
    logic              b_func_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_p_reg.x   <= rayobb_pkg::P_W'(cen_x) - rayobb_pkg::P_W'(a_reg.origin_x);
            b_p_reg.y   <= rayobb_pkg::P_W'(cen_y) - rayobb_pkg::P_W'(a_reg.origin_y);
            b_p_reg.z   <= rayobb_pkg::P_W'(cen_z) - rayobb_pkg::P_W'(a_reg.origin_z);
            b_dir_reg.x <= a_reg.dir_x;
            b_dir_reg.y <= a_reg.dir_y;
            b_dir_reg.z <= a_reg.dir_z;
            b_len_reg   <= a_reg.segment_length;
            b_func_reg  <= a_reg.func;
        end
    end

    // stages c, d: dot products
    logic signed [rayobb_pkg::E_W-1:0] dot_e [3];
    logic signed [rayobb_pkg::F_W-1:0] dot_f [3];
    for (genvar j = 0; j < 3; j++)
    begin : g_dot
        rayobb_dot u_dot (
            .clk  (clk),
            .en   (en),
            .axis (axis[j]),
            .p    (b_p_reg),
            .dir  (b_dir_reg),
            .e    (dot_e[j]),
            .f    (dot_f[j])
        );
    end

    logic [LW-1:0] c_len_reg, d_len_reg;
    logic          c_func_reg, d_func_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_len_reg  <= b_len_reg;
            c_func_reg <= b_func_reg;
            d_len_reg  <= c_len_reg;
            d_func_reg <= c_func_reg;
        end
    end

    // stage e: slab numerators and parallel test
    logic signed [rayobb_pkg::N_W-1:0] n1_reg [3];
    logic signed [rayobb_pkg::N_W-1:0] n2_reg [3];
    logic signed [rayobb_pkg::F_W-1:0] f_reg  [3];
    side_t                             e_side_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                n1_reg[j] <= rayobb_pkg::N_W'(dot_e[j]) + rayobb_pkg::N_W'(ext[j]);
                n2_reg[j] <= rayobb_pkg::N_W'(dot_e[j]) - rayobb_pkg::N_W'(ext[j]);
                f_reg[j]  <= dot_f[j];
                e_side_reg.par[j] <= dot_f[j] == '0;
                // only a parallel slab can fail here
                e_side_reg.pok[j] <= (dot_f[j] != '0) ||
                    !((rayobb_pkg::N_W'(dot_e[j]) < -rayobb_pkg::N_W'(ext[j])) ||
                      (rayobb_pkg::N_W'(dot_e[j]) > rayobb_pkg::N_W'(ext[j])));
            end
            e_side_reg.len  <= d_len_reg;
            e_side_reg.func <= d_func_reg;
        end
    end

    // dividers
    logic signed [31:0] t1 [3];
    logic signed [31:0] t2 [3];
    for (genvar j = 0; j < 3; j++)
    begin : g_div
        rayobb_div u_div1 (
            .clk (clk), .en (en), .num (n1_reg[j]), .den (f_reg[j]), .t (t1[j])
        );
        rayobb_div u_div2 (
            .clk (clk), .en (en), .num (n2_reg[j]), .den (f_reg[j]), .t (t2[j])
        );
    end

    side_t side_reg [rayobb_pkg::DIV_LAT];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= e_side_reg;
            for (int k = 1; k < rayobb_pkg::DIV_LAT; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // stage g: order each slab's entry and exit
    logic signed [31:0] lo_reg [3];
    logic signed [31:0] hi_reg [3];
    side_t              g_side_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                lo_reg[j] <= (t1[j] > t2[j]) ? t2[j] : t1[j];
                hi_reg[j] <= (t1[j] > t2[j]) ? t1[j] : t2[j];
            end
            g_side_reg <= side_reg[rayobb_pkg::DIV_LAT-1];
        end
    end

    // stage h: merge intervals
    logic signed [31:0] tmin_next, tmax_next;
    always_comb
    begin
        tmin_next = rayobb_pkg::T_LOW;
        tmax_next = rayobb_pkg::T_HIGH;
        for (int j = 0; j < 3; j++)
        begin
            if (!g_side_reg.par[j])
            begin
                if (lo_reg[j] > tmin_next)
                    tmin_next = lo_reg[j];
                if (hi_reg[j] < tmax_next)
                    tmax_next = hi_reg[j];
            end
        end
    end

    logic signed [31:0] tmin_reg, tmax_reg;
    logic               h_ok_reg;
    logic [LW-1:0]      h_len_reg;
    logic               h_func_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tmin_reg   <= tmin_next;
            tmax_reg   <= tmax_next;
            h_ok_reg   <= &g_side_reg.pok;
            h_len_reg  <= g_side_reg.len;
            h_func_reg <= g_side_reg.func;
        end
    end

    // stage i: mode select
    logic signed [32:0] len_s, tmin_s, tmax_s;
    logic               hit_next;
    logic signed [31:0] dist_next;
    always_comb
    begin
        len_s     = {2'b00, h_len_reg};
        tmin_s    = 33'(tmin_reg);
        tmax_s    = 33'(tmax_reg);
        hit_next  = h_ok_reg && !(tmin_reg > tmax_reg) && !(tmax_reg < 0);
        dist_next = tmax_reg;
        if (!h_func_reg)
        begin
            if (tmin_reg > 0)
                dist_next = tmin_reg;
        end
        else if (tmin_reg > 0 && tmin_s <= len_s)
        begin
            dist_next = tmin_reg;
        end
        else if (tmax_s > len_s)
        begin
            hit_next = 1'b0;
        end
    end

    rayobb_pkg::out_t i_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_reg.hit      <= hit_next;
            i_reg.distance <= hit_next ? dist_next[LW-1:0] : '0;
        end
    end

    // output skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_full_reg <= 1'b0;
        else if (skid_full_reg)
            skid_full_reg <= out_stall;
        else
            skid_full_reg <= vld_reg[LAST] && out_stall;
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg)
            skid_reg <= i_reg;
    end

    assign out_valid = skid_full_reg || vld_reg[LAST];
    assign out_data  = skid_full_reg ? skid_reg : i_reg;

    `ASSERT_NEXT(a_hold_frozen, clk, rst_n, skid_full_reg, $stable(vld_reg))
    `ASSERT_CLK(a_miss_zero, clk, rst_n, !(out_valid && !out_data.hit) || out_data.distance == '0)
    `ASSERT_CLK(a_skid_cause, clk, rst_n, !$rose(skid_full_reg) || $past(out_stall && vld_reg[LAST]))
endmodule
`default_nettype wire
